FILE: design/rect_polar_converter_unit_assert.svh
`ifndef RECT_POLAR_CONVERTER_UNIT_ASSERT_SVH
`define RECT_POLAR_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rect/polar converter check failed");

// next-cycle implication
`define RPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rect/polar converter check failed");

`endif

FILE: design/rpc_pkg.sv
package rpc_pkg;

  // number of unrolled cordic stages, 8 to 24
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;

  localparam int IN_W        = 16;
  localparam int FIELD_W     = 17;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  localparam int FRAC_BITS = 16;
  localparam int XW        = 35;  // x and y, q.16
  localparam int ZW        = 28;  // angle accumulator, q.24 radians

  // inverse gain in q.30, product split into a high and a low part of x
  localparam int LO_W   = 17;
  localparam int HI_W   = XW - LO_W;
  localparam int GAIN_W = 30;
  localparam int PH_W   = HI_W + GAIN_W;
  localparam int PL_W   = LO_W + GAIN_W;
  localparam int SUM_W  = 66;
  localparam int DSC_W  = 20;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = GAIN_W'(652032874);

  localparam logic signed [ZW-1:0] PI_Q24      = ZW'(52707179);
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(26353589);
  localparam logic signed [ZW-1:0] TWO_PI_Q24  = ZW'(105414357);

  localparam int DEG_WRAP_Q6 = 23040;
  localparam int DEG2RAD_Q16 = 146409;
  localparam int MAG_MAX     = 46341;
  localparam int COMP_MAX    = 32768;
  localparam int ANG_LIM     = 51472;

  localparam logic [MODE_W-1:0] MODE_RECT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POLAR = 2'd1;

  localparam int ATAN_Q24 [TABLE_LEN] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef enum logic [1:0] {
    KIND_RECT,
    KIND_POLAR,
    KIND_BAD
  } rpc_kind_e;

  // first pipeline stage: wrapped degree magnitude
  typedef struct packed {
    rpc_kind_e               kind;
    logic                    zero;
    logic signed [IN_W-1:0]  a;
    logic signed [IN_W-1:0]  b;
    logic [14:0]             m;
    logic                    neg;
  } rpc_s1_t;

  // side data that rides along the cordic stages
  typedef struct packed {
    rpc_kind_e                 kind;
    logic                      zero;
    logic signed [IN_W-1:0]    a;
    logic signed [IN_W-1:0]    b;
    logic signed [FIELD_W-1:0] ang;
  } rpc_side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rpc_vec_t;

  typedef struct packed {
    rpc_side_t               side;
    logic signed [PH_W-1:0]  ph_x;
    logic [PL_W-1:0]         pl_x;
    logic signed [PH_W-1:0]  ph_y;
    logic [PL_W-1:0]         pl_y;
  } rpc_d1_t;

  typedef struct packed {
    logic                      bad;
    logic signed [FIELD_W-1:0] ang;
    logic signed [FIELD_W-1:0] mag;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] x;
  } rpc_res_t;

endpackage

FILE: design/rpc_cordic.sv
module rpc_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ce_i,
  input  logic              vld_i,
  input  rpc_pkg::rpc_side_t side_i,
  input  rpc_pkg::rpc_vec_t  vec_i,
  output logic              vld_o,
  output rpc_pkg::rpc_side_t side_o,
  output rpc_pkg::rpc_vec_t  vec_o
);
  import rpc_pkg::*;

  logic [CORDIC_STAGES-1:0] vld_q;
  logic [CORDIC_STAGES-1:0] vld_s;
  rpc_side_t                side_q [CORDIC_STAGES];
  rpc_side_t                side_s [CORDIC_STAGES];
  rpc_vec_t                 vec_q  [CORDIC_STAGES];
  rpc_vec_t                 vec_s  [CORDIC_STAGES];
  rpc_vec_t                 vec_d  [CORDIC_STAGES];

  // stage inputs: the entry beat for stage 0, the previous register otherwise
  assign vld_s = {vld_q[CORDIC_STAGES-2:0], vld_i};

  always_comb begin
    side_s[0] = side_i;
    vec_s[0]  = vec_i;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      side_s[i] = side_q[i-1];
      vec_s[i]  = vec_q[i-1];
    end
  end

  // one micro-rotation per stage, shift amount fixed by the stage
  always_comb begin
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] t;
    logic                 sel;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs  = $signed(vec_s[i].x) >>> i;
      ys  = $signed(vec_s[i].y) >>> i;
      t   = ZW'(ATAN_Q24[i]);
      // vectoring drives y to zero, rotation drives z to zero
      sel = (side_s[i].kind == KIND_RECT) ? ~vec_s[i].y[XW-1] : vec_s[i].z[ZW-1];
      if (sel) begin
        vec_d[i].x = vec_s[i].x + ys;
        vec_d[i].y = vec_s[i].y - xs;
        vec_d[i].z = vec_s[i].z + t;
      end else begin
        vec_d[i].x = vec_s[i].x - ys;
        vec_d[i].y = vec_s[i].y + xs;
        vec_d[i].z = vec_s[i].z - t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= vld_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        vec_q[i]  <= vec_d[i];
        side_q[i] <= side_s[i];
      end
    end
  end

  assign vld_o  = vld_q[CORDIC_STAGES-1];
  assign side_o = side_q[CORDIC_STAGES-1];
  assign vec_o  = vec_q[CORDIC_STAGES-1];

endmodule

FILE: design/rect_polar_converter_unit.sv
// rectangular/polar vector converter, unrolled cordic
// input beat: tuser = mode (0 rectangular, 1 polar, 2 and 3 invalid),
//   tdata = first value (x or magnitude), second value (y or degrees q10.6)
// output beat: tdata = x, y, magnitude, angle in radians q3.13, 17 bits each,
//   tuser = bad mode flag; an invalid mode gives all-zero tdata
// throughput: one beat per clock while s_axis_tready is high; every stage is a
//   register stage under a common enable, so beats follow each other with no gap
// path: from the accepting edge to tvalid a beat passes the degree wrap,
//   degree to radian multiply and quadrant pre-rotation registers, the cordic
//   stage registers, the gain partial product and sum registers and the
//   output register
// stall: a two-entry output buffer (output register plus skid register)
//   sits behind the pipeline; while the receiver holds tready low, one more
//   beat still drains into the skid register, then s_axis_tready falls and
//   the whole pipeline freezes, losing and repeating nothing
// reset: all valid bits clear, s_axis_tready comes up high, nothing in flight
module rect_polar_converter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_value [15:0], second_value [31:16]
  input  logic [rpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // mode [1:0]
  input  logic [rpc_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_x [16:0], out_y [33:17], out_magnitude [50:34], out_angle [67:51], zeros
  output logic [rpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // bad_mode [0]
  output logic                             m_axis_tuser
);
  import rpc_pkg::*;

  localparam logic signed [ZW-1:0]    ANG_RND = ZW'(1024);
  localparam logic signed [SUM_W-1:0] DSC_RND = SUM_W'(64'h0000_2000_0000_0000);

  function automatic logic signed [FIELD_W-1:0] clamp_f(
    input logic signed [DSC_W-1:0] v,
    input logic signed [DSC_W-1:0] lo,
    input logic signed [DSC_W-1:0] hi
  );
    logic signed [DSC_W-1:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return FIELD_W'(r);
  endfunction

  logic      ce;
  logic      mv;

  logic      v1_q, v2_q, v3_q, d1_vld_q, d2_vld_q;
  rpc_s1_t   s1_d, s1_q;
  rpc_side_t s2_d, s2_q, s3_side_q;
  rpc_vec_t  s3_d, s3_q;
  logic      c_vld;
  rpc_side_t c_side;
  rpc_vec_t  c_vec;
  rpc_d1_t   d1_d, d1_q;
  rpc_res_t  d2_d, d2_q;

  logic      out_vld_d, out_vld_q, skd_vld_d, skd_vld_q;
  rpc_res_t  out_d, out_q, skd_d, skd_q;

  // pipeline moves whenever the skid register is free
  assign ce            = ~skd_vld_q;
  assign s_axis_tready = ce;
  assign mv            = ce & d2_vld_q;

  // stage 1: mode decode and degree wrap modulo 360, sign kept
  always_comb begin
    logic signed [IN_W-1:0] b;
    logic signed [IN_W:0]   bext;
    logic [IN_W:0]          babs;
    logic [IN_W:0]          mred;
    b    = $signed(s_axis_tdata[2*IN_W-1:IN_W]);
    bext = (IN_W+1)'(b);
    babs = bext[IN_W] ? (IN_W+1)'(-bext) : (IN_W+1)'(bext);
    mred = (babs >= (IN_W+1)'(DEG_WRAP_Q6)) ? babs - (IN_W+1)'(DEG_WRAP_Q6) : babs;
    case (s_axis_tuser)
      MODE_RECT:  s1_d.kind = KIND_RECT;
      MODE_POLAR: s1_d.kind = KIND_POLAR;
      default:    s1_d.kind = KIND_BAD;
    endcase
    s1_d.a    = $signed(s_axis_tdata[IN_W-1:0]);
    s1_d.b    = b;
    s1_d.zero = (s_axis_tdata[2*IN_W-1:0] == '0);
    s1_d.m    = mred[14:0];
    s1_d.neg  = b[IN_W-1];
  end

  // stage 2: degrees q10.6 to radians q3.13, round half up on the magnitude
  always_comb begin
    logic [31:0]  prod;
    logic [15:0]  q;
    prod = 32'(s1_q.m) * 32'(DEG2RAD_Q16) + 32'(32768);
    q    = prod[31:16];
    s2_d.kind = s1_q.kind;
    s2_d.zero = s1_q.zero;
    s2_d.a    = s1_q.a;
    s2_d.b    = s1_q.b;
    s2_d.ang  = s1_q.neg ? -$signed(FIELD_W'(q)) : $signed(FIELD_W'(q));
  end

  // stage 3: quarter-turn pre-rotation into the right half plane
  always_comb begin
    logic signed [XW-1:0] aq;
    logic signed [XW-1:0] bq;
    logic signed [ZW-1:0] zp;
    aq = XW'(s2_q.a) <<< FRAC_BITS;
    bq = XW'(s2_q.b) <<< FRAC_BITS;
    zp = ZW'(s2_q.ang) <<< 11;
    if (zp > PI_Q24) begin
      zp = zp - TWO_PI_Q24;
    end
    if (zp < -PI_Q24) begin
      zp = zp + TWO_PI_Q24;
    end
    case (s2_q.kind)
      KIND_POLAR: begin
        if (zp > HALF_PI_Q24) begin
          s3_d.x = '0;
          s3_d.y = aq;
          s3_d.z = zp - HALF_PI_Q24;
        end else if (zp < -HALF_PI_Q24) begin
          s3_d.x = '0;
          s3_d.y = -aq;
          s3_d.z = zp + HALF_PI_Q24;
        end else begin
          s3_d.x = aq;
          s3_d.y = '0;
          s3_d.z = zp;
        end
      end
      default: begin
        if (s2_q.a < 0) begin
          if (s2_q.b >= 0) begin
            s3_d.x = bq;
            s3_d.y = -aq;
            s3_d.z = HALF_PI_Q24;
          end else begin
            s3_d.x = -bq;
            s3_d.y = aq;
            s3_d.z = -HALF_PI_Q24;
          end
        end else begin
          s3_d.x = aq;
          s3_d.y = bq;
          s3_d.z = '0;
        end
      end
    endcase
  end

  rpc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .vld_i  (v3_q),
    .side_i (s3_side_q),
    .vec_i  (s3_q),
    .vld_o  (c_vld),
    .side_o (c_side),
    .vec_o  (c_vec)
  );

  // gain stage 1: partial products of x and y with the inverse gain, and the rounded angle in rectangular mode
  always_comb begin
    logic signed [HI_W-1:0] xh;
    logic signed [HI_W-1:0] yh;
    xh = $signed(c_vec.x[XW-1:LO_W]);
    yh = $signed(c_vec.y[XW-1:LO_W]);
    d1_d.side = c_side;
    if (c_side.kind == KIND_RECT) begin
      d1_d.side.ang = FIELD_W'((c_vec.z + ANG_RND) >>> 11);
    end
    d1_d.ph_x = PH_W'(xh) * $signed(PH_W'(INV_GAIN_Q30));
    d1_d.pl_x = PL_W'(c_vec.x[LO_W-1:0]) * PL_W'(INV_GAIN_Q30);
    d1_d.ph_y = PH_W'(yh) * $signed(PH_W'(INV_GAIN_Q30));
    d1_d.pl_y = PL_W'(c_vec.y[LO_W-1:0]) * PL_W'(INV_GAIN_Q30);
  end

  // gain stage 2: sum, round, drop the fraction, saturate and pick fields
  always_comb begin
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [DSC_W-1:0] dx;
    logic signed [DSC_W-1:0] dy;
    sx = (SUM_W'(d1_q.ph_x) <<< LO_W) + $signed(SUM_W'(d1_q.pl_x)) + DSC_RND;
    sy = (SUM_W'(d1_q.ph_y) <<< LO_W) + $signed(SUM_W'(d1_q.pl_y)) + DSC_RND;
    dx = DSC_W'(sx >>> 46);
    dy = DSC_W'(sy >>> 46);
    d2_d = '0;
    case (d1_q.side.kind)
      KIND_RECT: begin
        d2_d.x = FIELD_W'(d1_q.side.a);
        d2_d.y = FIELD_W'(d1_q.side.b);
        if (!d1_q.side.zero) begin
          d2_d.mag = clamp_f(dx, '0, DSC_W'(MAG_MAX));
          d2_d.ang = d1_q.side.ang;
        end
      end
      KIND_POLAR: begin
        d2_d.x   = clamp_f(dx, -DSC_W'(COMP_MAX), DSC_W'(COMP_MAX));
        d2_d.y   = clamp_f(dy, -DSC_W'(COMP_MAX), DSC_W'(COMP_MAX));
        d2_d.mag = FIELD_W'(d1_q.side.a);
        d2_d.ang = d1_q.side.ang;
      end
      default: begin
        d2_d.bad = 1'b1;
      end
    endcase
  end

  // output register with a skid register behind it
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    skd_vld_d = skd_vld_q;
    skd_d     = skd_q;
    if (!out_vld_q || m_axis_tready) begin
      if (skd_vld_q) begin
        out_vld_d = 1'b1;
        out_d     = skd_q;
        skd_vld_d = 1'b0;
      end else begin
        out_vld_d = mv;
        out_d     = d2_q;
      end
    end else if (mv) begin
      skd_vld_d = 1'b1;
      skd_d     = d2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      d1_vld_q  <= 1'b0;
      d2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      if (ce) begin
        v1_q     <= s_axis_tvalid;
        v2_q     <= v1_q;
        v3_q     <= v2_q;
        d1_vld_q <= c_vld;
        d2_vld_q <= d1_vld_q;
      end
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      s3_side_q <= s2_q;
      d1_q      <= d1_d;
      d2_q      <= d2_d;
    end
    out_q <= out_d;
    skd_q <= skd_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-4*FIELD_W){1'b0}},
                          out_q.ang, out_q.mag, out_q.y, out_q.x};
  assign m_axis_tuser  = out_q.bad;

endmodule

FILE: design/rpc_checker.sv
`include "rect_polar_converter_unit_assert.svh"

module rpc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);
  import rpc_pkg::*;

  logic signed [FIELD_W-1:0] out_ang;

  assign out_ang = m_axis_tdata[4*FIELD_W-1:3*FIELD_W];

  // a held result beat keeps its payload
  `RPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // input side only backs up while a result waits
  `RPC_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid)

  // invalid mode zeroes every field
  `RPC_ASSERT_NOW(a_bad_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

  // angle stays within one turn either side of zero
  `RPC_ASSERT_NOW(a_ang_range, m_axis_tvalid, out_ang <= ANG_LIM && out_ang >= -ANG_LIM)

endmodule

bind rect_polar_converter_unit rpc_checker u_rpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/conv_scoreboard_pkg.sv
package conv_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import rpc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_BAD_LO = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD_HI = 2'd3;

  localparam int     ARCTAN_LEN  = 24;
  localparam int     STAGE_COUNT = (CORDIC_STAGES > ARCTAN_LEN) ? ARCTAN_LEN : CORDIC_STAGES;
  localparam longint ARCTAN_Q24 [ARCTAN_LEN] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  localparam longint GAIN_INV_Q30  = 652032874;
  localparam longint ROUND_BIT_45  = 64'sd35184372088832;
  localparam longint RAD_PI        = 52707179;
  localparam longint RAD_HALF_PI   = 26353589;
  localparam longint RAD_TWO_PI    = 105414357;
  localparam longint FULL_TURN_Q6  = 23040;
  localparam longint DEG_TO_RAD_Q16 = 146409;
  localparam longint LEN_CEIL      = 46341;
  localparam longint AXIS_CEIL     = 32768;

  typedef struct packed {
    logic                bad;
    logic signed [16:0]  ang;
    logic signed [16:0]  mag;
    logic signed [16:0]  y;
    logic signed [16:0]  x;
  } vector_set_t;

  class vector_scoreboard;
    vector_set_t pending_sets[$];
    int          errors;
    int          results_seen;

    function new();
      errors       = 0;
      results_seen = 0;
    endfunction

    // q.16 value times inverse gain, rounded to an integer
    static function longint unscale(longint v);
      return (v * GAIN_INV_Q30 + ROUND_BIT_45) >>> 46;
    endfunction

    static function longint limit(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    static function vector_set_t convert_vector(logic [MODE_W-1:0] mode,
                                                logic signed [15:0] first,
                                                logic signed [15:0] second);
      vector_set_t r;
      longint      a, b, px, py, acc, nx, ny, rem, deg_abs, rad;
      r = '0;
      a = first;
      b = second;
      if (mode == MODE_RECT) begin
        r.x = 17'(a);
        r.y = 17'(b);
        if (a != 0 || b != 0) begin
          px  = a * 65536;
          py  = b * 65536;
          acc = 0;
          // left half plane: quarter turn toward the positive x axis
          if (px < 0) begin
            if (py >= 0) begin
              nx = py; ny = -px; acc = RAD_HALF_PI;
            end else begin
              nx = -py; ny = px; acc = -RAD_HALF_PI;
            end
            px = nx; py = ny;
          end
          for (int i = 0; i < STAGE_COUNT; i++) begin
            if (py >= 0) begin
              nx = px + (py >>> i); ny = py - (px >>> i); acc += ARCTAN_Q24[i];
            end else begin
              nx = px - (py >>> i); ny = py + (px >>> i); acc -= ARCTAN_Q24[i];
            end
            px = nx; py = ny;
          end
          r.mag = 17'(limit(unscale(px), 0, LEN_CEIL));
          r.ang = 17'((acc + 1024) >>> 11);
        end
      end else if (mode == MODE_POLAR) begin
        rem     = b % FULL_TURN_Q6;
        deg_abs = (rem < 0) ? -rem : rem;
        rad     = (deg_abs * DEG_TO_RAD_Q16 + 32768) >>> 16;
        if (rem < 0) rad = -rad;
        r.ang = 17'(rad);
        r.mag = 17'(a);
        acc   = rad * 2048;
        if (acc > RAD_PI) acc -= RAD_TWO_PI;
        if (acc < -RAD_PI) acc += RAD_TWO_PI;
        if (acc > RAD_HALF_PI) begin
          px = 0; py = a * 65536; acc -= RAD_HALF_PI;
        end else if (acc < -RAD_HALF_PI) begin
          px = 0; py = -a * 65536; acc += RAD_HALF_PI;
        end else begin
          px = a * 65536; py = 0;
        end
        for (int i = 0; i < STAGE_COUNT; i++) begin
          if (acc >= 0) begin
            nx = px - (py >>> i); ny = py + (px >>> i); acc -= ARCTAN_Q24[i];
          end else begin
            nx = px + (py >>> i); ny = py - (px >>> i); acc += ARCTAN_Q24[i];
          end
          px = nx; py = ny;
        end
        r.x = 17'(limit(unscale(px), -AXIS_CEIL, AXIS_CEIL));
        r.y = 17'(limit(unscale(py), -AXIS_CEIL, AXIS_CEIL));
      end else begin
        r.bad = 1'b1;
      end
      return r;
    endfunction

    function void note_input(logic [MODE_W-1:0] mode, logic signed [15:0] first,
                             logic signed [15:0] second);
      pending_sets.push_back(convert_vector(mode, first, second));
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
      vector_set_t want, got;
      got.x   = tdata[16:0];
      got.y   = tdata[33:17];
      got.mag = tdata[50:34];
      got.ang = tdata[67:51];
      got.bad = tuser;
      results_seen++;
      if (pending_sets.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing pending, tdata %h tuser %b",
                 $realtime, tdata, tuser);
        return;
      end
      want = pending_sets.pop_front();
      if (got.x !== want.x) begin
        errors++;
        $display("%0t: x expected %0d actual %0d", $realtime, want.x, got.x);
      end
      if (got.y !== want.y) begin
        errors++;
        $display("%0t: y expected %0d actual %0d", $realtime, want.y, got.y);
      end
      if (got.mag !== want.mag) begin
        errors++;
        $display("%0t: magnitude expected %0d actual %0d", $realtime, want.mag, got.mag);
      end
      if (got.ang !== want.ang) begin
        errors++;
        $display("%0t: angle expected %0d actual %0d", $realtime, want.ang, got.ang);
      end
      if (got.bad !== want.bad) begin
        errors++;
        $display("%0t: bad mode expected %0b actual %0b", $realtime, want.bad, got.bad);
      end
      if (tdata[OUT_TDATA_W-1:68] !== '0) begin
        errors++;
        $display("%0t: tdata padding expected 0 actual %h", $realtime,
                 tdata[OUT_TDATA_W-1:68]);
      end
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpc_pkg::*;
  import conv_scoreboard_pkg::*;

  localparam int RANDOM_VECTORS = 1500;
  localparam int QUIET_LO       = 700;
  localparam int QUIET_HI       = 1000;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 150;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [MODE_W-1:0]       s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tuser;

  vector_scoreboard board;
  int               vectors_sent = 0;
  bit               send_quiet   = 1'b0;

  rect_polar_converter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_vector(input logic [MODE_W-1:0] mode, input logic [15:0] first,
                             input logic [15:0] second);
    while (!send_quiet && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second, first};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_input(mode, first, second);
    vectors_sent++;
  endtask

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = 16'($urandom_range(0, 2)) - 16'd1;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_degrees();
    int k;
    k = $urandom_range(0, 10) - 5;
    // quadrant boundaries now and then, else anything
    if ($urandom_range(0, 7) == 0) return 16'(k * 5760);
    return pick_value();
  endfunction

  initial begin
    int          pick;
    logic [15:0] first, second;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rectangular corners, zero vector, negative x on the axis
    send_vector(MODE_RECT, 16'd0, 16'd0);
    send_vector(MODE_RECT, 16'h7fff, 16'd0);
    send_vector(MODE_RECT, 16'h8000, 16'd0);
    send_vector(MODE_RECT, 16'hffff, 16'd0);
    send_vector(MODE_RECT, 16'd0, 16'h7fff);
    send_vector(MODE_RECT, 16'd0, 16'h8000);
    send_vector(MODE_RECT, 16'h7fff, 16'h7fff);
    send_vector(MODE_RECT, 16'h8000, 16'h8000);
    send_vector(MODE_RECT, 16'h8000, 16'h7fff);
    send_vector(MODE_RECT, 16'd1, 16'hffff);
    // polar: wrap, quarter turns, half turns, negative magnitude
    send_vector(MODE_POLAR, 16'd1000, 16'd0);
    send_vector(MODE_POLAR, 16'h7fff, 16'h7fff);
    send_vector(MODE_POLAR, 16'h7fff, 16'h8000);
    send_vector(MODE_POLAR, 16'h8000, 16'd5760);
    send_vector(MODE_POLAR, 16'h8000, -16'sd11520);
    send_vector(MODE_POLAR, 16'h7fff, 16'd11520);
    send_vector(MODE_POLAR, 16'd1000, 16'd23040);
    send_vector(MODE_POLAR, 16'hffff, -16'sd5760);
    send_vector(MODE_POLAR, 16'd0, 16'd1234);
    send_vector(MODE_POLAR, 16'h8000, 16'd17280);
    send_vector(MODE_BAD_LO, 16'h8000, 16'h7fff);
    send_vector(MODE_BAD_HI, 16'h7fff, 16'h8000);

    for (int n = 0; n < RANDOM_VECTORS; n++) begin
      send_quiet = (n >= QUIET_LO && n < QUIET_HI);
      pick = $urandom_range(0, 9);
      first = pick_value();
      if (pick < 4) begin
        second = pick_value();
        send_vector(MODE_RECT, first, second);
      end else if (pick < 8) begin
        second = pick_degrees();
        send_vector(MODE_POLAR, first, second);
      end else begin
        second = pick_value();
        send_vector((pick == 8) ? MODE_BAD_LO : MODE_BAD_HI, first, second);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending_sets.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.pending_sets.size() != 0) begin
      board.errors++;
      $display("%0t: %0d results never arrived", $realtime, board.pending_sets.size());
    end
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: random back-pressure, one long hold-off, a quiet window
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held && board.results_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (board.results_seen >= QUIET_LO && board.results_seen < QUIET_HI) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 16);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
